>>> design/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg: shared types and constants of the slotted link servicer
// Request and result structs, link byte codes, link phases and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sls_pkg;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  rx_byte;
        logic [7:0]  slot_id;
        logic [15:0] data_id;
        logic        continuous;
        logic        persistent;
        logic [3:0]  byte_index;
    } t_in;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic       accepted;
        logic [7:0] slot_out;
        logic [7:0] read_data;
        logic       slot_is_open;
        logic       slot_is_connected;
        logic       link_ready;
    } t_out;

    // Request codes.
    localparam logic [2:0] FN_POLL   = 3'd0;
    localparam logic [2:0] FN_RXBYTE = 3'd1;
    localparam logic [2:0] FN_TXDONE = 3'd2;
    localparam logic [2:0] FN_OPEN   = 3'd3;
    localparam logic [2:0] FN_CLOSE  = 3'd4;
    localparam logic [2:0] FN_ACK    = 3'd5;
    localparam logic [2:0] FN_READ   = 3'd6;

    // Link phases.
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_WAIT_REPLY = 3'd1;
    localparam logic [2:0] PH_REPLY_SEEN = 3'd2;
    localparam logic [2:0] PH_HEADER     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD    = 3'd4;
    localparam logic [2:0] PH_READY      = 3'd5;

    // Link bytes.
    localparam logic [7:0] SYNC_TX   = 8'hA5;
    localparam logic [7:0] SYNC_RX   = 8'hA6;
    localparam logic [7:0] HS_START  = 8'h10;
    localparam logic [7:0] HS_REPLY  = 8'h01;
    localparam logic [7:0] HS_DONE   = 8'h12;
    localparam logic [7:0] FR_OPEN   = 8'h20;
    localparam logic [7:0] FR_CLOSE  = 8'h21;
    localparam logic [7:0] FR_ACK    = 8'h22;
    localparam logic [7:0] CMD_CONN  = 8'h30;
    localparam logic [7:0] CMD_CLOSE = 8'h31;
    localparam logic [7:0] CMD_DATA  = 8'h40;

    // Kinds of queued operations.
    localparam logic [2:0] KIND_CLOSE = 3'd2;
    localparam logic [2:0] KIND_ACK   = 3'd3;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_HS,
        DP_TAKE,
        DP_TXDONE,
        DP_SCAN_START,
        DP_SCAN_NEXT,
        DP_OPEN_COMMIT,
        DP_REQ_RD,
        DP_REQ_COMMIT,
        DP_READ_COMMIT,
        DP_CMD_RD,
        DP_CMD_EXEC,
        DP_SWEEP,
        DP_POP
    } t_dp_op;

    typedef struct packed {
        logic   load;
        t_dp_op op;
        logic   emit_adv;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] phase;
        logic       tx_busy;
        logic       lifo_empty;
        logic       sid_ok;
        logic       cmd_ok;
        logic       cmd_data;
        logic       scan_free;
        logic       scan_end;
        logic       sweep_last;
        logic       emit_last;
    } t_dp_stat;

endpackage

>>> design/slotted_link_servicer.sv
// ----------------------------------------------------------------------------
// slotted_link_servicer: byte-link handshake, deframer and slot servicer
// Top level joining the sequencing controller and the storage datapath.
// ----------------------------------------------------------------------------
// Usage. Requests enter on i_valid/o_ready with the payload in i_item; each
// request yields one to seven result transactions on o_valid/i_ready, and the
// final one of a request carries last. A poll that sends a frame yields one
// transaction per frame byte; every other request yields a single one.
// The block works on one request at a time: o_ready returns in the cycle
// after the last result transaction of the previous request is taken.
// An open walks the slot flag memory one slot per cycle, and a poll that
// executes a received data command sweeps the slot store one byte per cycle.
// The flag and data memories each have one write and one read port; those
// ports set the per-slot and per-byte pacing above.
// Reset clears the link phase, transmitter busy flag, stack level and the
// per-slot valid bits, so every slot reads closed and unconnected with no
// clearing pass. Slot data is not cleared and is defined once written.
// When the receiver holds i_ready low, the current result stays on o_result
// and no further request is taken until all results are delivered.
// ----------------------------------------------------------------------------
module slotted_link_servicer #(
    parameter int NUM_SLOTS     = 256,
    parameter int SLOT_BYTES    = 16,
    parameter int PENDING_DEPTH = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sls_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output sls_pkg::t_out o_result
);

    // Command and status bundles between the two halves.
    sls_pkg::t_dp_cmd  dp_cmd;
    sls_pkg::t_dp_stat dp_stat;

    // The controller owns the handshakes and the order of datapath actions.
    sls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // The datapath holds the link, stack and slot state and builds the result transactions.
    sls_datapath #(
        .NUM_SLOTS     (NUM_SLOTS),
        .SLOT_BYTES    (SLOT_BYTES),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_result (o_result)
    );

endmodule

>>> design/sls_datapath.sv
// ----------------------------------------------------------------------------
// sls_datapath: storage and arithmetic of the slotted link servicer
// Holds link state, receive frame, operation stack, slot flag and slot data
// memories and the result registers; acts on one command per cycle.
// ----------------------------------------------------------------------------
module sls_datapath #(
    parameter int NUM_SLOTS     = 256,
    parameter int SLOT_BYTES    = 16,
    parameter int PENDING_DEPTH = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sls_pkg::t_in      i_item,
    input  sls_pkg::t_dp_cmd  i_cmd,
    output sls_pkg::t_dp_stat o_stat,
    output sls_pkg::t_out     o_result
);

    localparam int SIW   = $clog2(NUM_SLOTS);
    localparam int WORDS = NUM_SLOTS * SLOT_BYTES;
    localparam int AW    = $clog2(WORDS);
    localparam int RXD   = SLOT_BYTES + 4;
    localparam int RXIW  = $clog2(RXD);
    localparam int CW    = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int LW    = $clog2(PENDING_DEPTH + 1);
    localparam int LIW   = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    sls_pkg::t_in r_req;
    logic [2:0]   r_phase;
    logic         r_busy;
    logic [8:0]   r_rxcnt;
    logic [7:0]   r_rxf [RXD];
    logic [26:0]  r_ops [PENDING_DEPTH];
    logic [LW-1:0] r_level;
    logic [1:0]   r_fmem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_fval;
    logic [1:0]   r_frd;
    logic         r_frd_val;
    logic [7:0]   r_smem [WORDS];
    logic [7:0]   r_srd;
    logic [SIW-1:0] r_scan;
    logic [CW-1:0]  r_sw;
    logic         r_acc;
    logic [7:0]   r_sout;
    logic [7:0]   r_rdat;
    logic         r_ropen;
    logic         r_rconn;
    logic [2:0]   r_ntx;
    logic [7:0]   r_tx [7];
    logic [2:0]   r_eidx;

    logic           sid_ok, cmd_ok, full, empty, req_ok, tb_store, emit_last;
    logic [SIW-1:0] sid_idx, cmd_idx, scan_first, scan_next, scan_last, fra, fwa;
    logic [1:0]     f_eff, fwd;
    logic           fwe;
    logic [LW-1:0]  lvl_m1;
    logic [26:0]    top;
    logic [2:0]     kind;
    logic [2:0]     pop_ntx;
    logic [7:0]     pop_tx [7];
    logic [8:0]     cnt_inc;
    logic [AW-1:0]  sra, swa;
    logic [7:0]     swd;

    assign sid_ok  = int'(r_req.slot_id) < NUM_SLOTS;
    assign sid_idx = r_req.slot_id[SIW-1:0];
    assign cmd_idx = r_rxf[3][SIW-1:0];
    assign cmd_ok  = (r_rxf[0] == sls_pkg::SYNC_RX) && (r_rxf[1] != 8'h00)
                     && (int'(r_rxf[3]) < NUM_SLOTS);
    assign f_eff   = r_frd_val ? r_frd : 2'b00;
    assign full    = r_level == LW'(PENDING_DEPTH);
    assign empty   = r_level == '0;
    assign req_ok  = !full && ((r_req.func == sls_pkg::FN_CLOSE) ? f_eff[0]
                                                                 : (f_eff == 2'b11));
    assign lvl_m1  = r_level - LW'(1);
    assign top     = r_ops[lvl_m1[LIW-1:0]];
    assign kind    = top[26:24];
    assign cnt_inc = r_rxcnt + 9'd1;

    assign scan_first = r_req.persistent ? SIW'(NUM_SLOTS - 1) : '0;
    assign scan_last  = r_req.persistent ? '0 : SIW'(NUM_SLOTS - 1);
    assign scan_next  = r_req.persistent ? r_scan - SIW'(1) : r_scan + SIW'(1);

    always_comb begin
        tb_store = 1'b0;
        if (r_phase == sls_pkg::PH_WAIT_REPLY || r_phase == sls_pkg::PH_HEADER) begin
            tb_store = r_rxcnt < 9'd3;
        end else if (r_phase == sls_pkg::PH_PAYLOAD) begin
            tb_store = int'(r_rxcnt) < RXD;
        end
    end

    // Frame for the operation on top of the stack.
    always_comb begin
        pop_ntx = 3'd0;
        for (int k = 0; k < 7; k++) begin
            pop_tx[k] = 8'h00;
        end
        pop_tx[0] = sls_pkg::SYNC_TX;
        if (kind <= 3'd1) begin
            pop_ntx   = 3'd7;
            pop_tx[1] = 8'h04;
            pop_tx[2] = sls_pkg::FR_OPEN;
            pop_tx[3] = {5'b00000, kind};
            pop_tx[4] = top[7:0];
            pop_tx[5] = top[15:8];
            pop_tx[6] = top[23:16];
        end else if (kind == sls_pkg::KIND_CLOSE || kind == sls_pkg::KIND_ACK) begin
            pop_ntx   = 3'd4;
            pop_tx[1] = 8'h01;
            pop_tx[2] = (kind == sls_pkg::KIND_CLOSE) ? sls_pkg::FR_CLOSE : sls_pkg::FR_ACK;
            pop_tx[3] = top[7:0];
        end
    end

    // Flag memory ports.
    always_comb begin
        unique case (i_cmd.op)
            sls_pkg::DP_REQ_RD:     fra = sid_idx;
            sls_pkg::DP_CMD_RD:     fra = cmd_idx;
            sls_pkg::DP_SCAN_START: fra = scan_first;
            sls_pkg::DP_SCAN_NEXT:  fra = scan_next;
            default:                fra = r_scan;
        endcase
        fwe = 1'b0;
        fwa = r_scan;
        fwd = f_eff | 2'b01;
        if (i_cmd.op == sls_pkg::DP_OPEN_COMMIT) begin
            fwe = !full;
        end else if (i_cmd.op == sls_pkg::DP_CMD_EXEC && cmd_ok) begin
            fwa = cmd_idx;
            if (r_rxf[2] == sls_pkg::CMD_CONN) begin
                fwe = 1'b1;
                fwd = f_eff | 2'b10;
            end else if (r_rxf[2] == sls_pkg::CMD_CLOSE) begin
                fwe = 1'b1;
                fwd = 2'b00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwe) begin
            r_fmem[fwa] <= fwd;
        end
        r_frd <= r_fmem[fra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fval    <= '0;
            r_frd_val <= 1'b0;
        end else begin
            if (fwe) begin
                r_fval[fwa] <= 1'b1;
            end
            r_frd_val <= r_fval[fra];
        end
    end

    // Slot data memory: the sweep writes, read requests read.
    assign sra = AW'(int'(sid_idx) * SLOT_BYTES + int'(r_req.byte_index));
    assign swa = AW'(int'(cmd_idx) * SLOT_BYTES + int'(r_sw));
    assign swd = (int'(r_sw) + 1 < int'(r_rxf[1])) ? r_rxf[RXIW'(int'(r_sw) + 4)] : 8'h00;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sls_pkg::DP_SWEEP) begin
            r_smem[swa] <= swd;
        end
        r_srd <= r_smem[sra];
    end

    // Link and stack control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sls_pkg::PH_IDLE;
            r_busy  <= 1'b0;
            r_rxcnt <= '0;
            r_level <= '0;
        end else begin
            unique case (i_cmd.op)
                sls_pkg::DP_HS: begin
                    r_busy  <= 1'b1;
                    r_rxcnt <= '0;
                    r_phase <= (r_phase == sls_pkg::PH_IDLE) ? sls_pkg::PH_WAIT_REPLY
                                                             : sls_pkg::PH_HEADER;
                end
                sls_pkg::DP_TAKE: begin
                    if (r_phase == sls_pkg::PH_WAIT_REPLY) begin
                        if (cnt_inc >= 9'd3) begin
                            r_rxcnt <= '0;
                            if (r_rxf[0] == sls_pkg::SYNC_RX && r_rxf[1] == 8'h00
                                && r_req.rx_byte == sls_pkg::HS_REPLY) begin
                                r_phase <= sls_pkg::PH_REPLY_SEEN;
                            end
                        end else begin
                            r_rxcnt <= cnt_inc;
                        end
                    end else if (r_phase == sls_pkg::PH_HEADER) begin
                        r_rxcnt <= cnt_inc;
                        if (cnt_inc >= 9'd3) begin
                            r_phase <= (r_rxf[1] != 8'h00) ? sls_pkg::PH_PAYLOAD
                                                           : sls_pkg::PH_READY;
                        end
                    end else if (r_phase == sls_pkg::PH_PAYLOAD) begin
                        r_rxcnt <= cnt_inc;
                        if (cnt_inc >= 9'd3 + {1'b0, r_rxf[1]}) begin
                            r_phase <= sls_pkg::PH_READY;
                        end
                    end
                end
                sls_pkg::DP_TXDONE: r_busy <= 1'b0;
                sls_pkg::DP_OPEN_COMMIT: begin
                    if (!full) begin
                        r_level <= r_level + LW'(1);
                    end
                end
                sls_pkg::DP_REQ_COMMIT: begin
                    if (req_ok) begin
                        r_level <= r_level + LW'(1);
                    end
                end
                sls_pkg::DP_CMD_EXEC: begin
                    r_phase <= sls_pkg::PH_HEADER;
                    r_rxcnt <= '0;
                end
                sls_pkg::DP_POP: begin
                    r_level <= lvl_m1;
                    if (pop_ntx != 3'd0) begin
                        r_busy <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Request, frame and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_item;
            r_acc   <= 1'b0;
            r_sout  <= 8'h00;
            r_rdat  <= 8'h00;
            r_ropen <= 1'b0;
            r_rconn <= 1'b0;
            r_ntx   <= 3'd0;
            r_eidx  <= 3'd0;
        end
        unique case (i_cmd.op)
            sls_pkg::DP_TAKE: begin
                if (tb_store) begin
                    r_rxf[r_rxcnt[RXIW-1:0]] <= r_req.rx_byte;
                end
            end
            sls_pkg::DP_HS: begin
                r_ntx   <= 3'd3;
                r_tx[0] <= sls_pkg::SYNC_TX;
                r_tx[1] <= 8'h00;
                r_tx[2] <= (r_phase == sls_pkg::PH_IDLE) ? sls_pkg::HS_START
                                                         : sls_pkg::HS_DONE;
                for (int k = 3; k < 7; k++) begin
                    r_tx[k] <= 8'h00;
                end
            end
            sls_pkg::DP_SCAN_START: r_scan <= scan_first;
            sls_pkg::DP_SCAN_NEXT:  r_scan <= scan_next;
            sls_pkg::DP_OPEN_COMMIT: begin
                if (!full) begin
                    r_ops[r_level[LIW-1:0]] <= {2'b00, r_req.continuous, r_req.data_id,
                                                8'(r_scan)};
                    r_acc  <= 1'b1;
                    r_sout <= 8'(r_scan);
                end
            end
            sls_pkg::DP_REQ_COMMIT: begin
                if (req_ok) begin
                    r_ops[r_level[LIW-1:0]] <= {(r_req.func == sls_pkg::FN_CLOSE)
                                                ? sls_pkg::KIND_CLOSE : sls_pkg::KIND_ACK,
                                                16'h0000, r_req.slot_id};
                    r_acc <= 1'b1;
                end
            end
            sls_pkg::DP_READ_COMMIT: begin
                r_ropen <= f_eff[0];
                r_rconn <= f_eff[1];
                r_rdat  <= (int'(r_req.byte_index) < SLOT_BYTES) ? r_srd : 8'h00;
            end
            sls_pkg::DP_CMD_EXEC: r_sw <= '0;
            sls_pkg::DP_SWEEP:    r_sw <= r_sw + CW'(1);
            sls_pkg::DP_POP: begin
                r_ntx <= pop_ntx;
                for (int k = 0; k < 7; k++) begin
                    r_tx[k] <= pop_tx[k];
                end
            end
            default: ;
        endcase
        if (i_cmd.emit_adv) begin
            r_eidx <= r_eidx + 3'd1;
        end
    end

    assign emit_last = (r_ntx == 3'd0) || (r_eidx == r_ntx - 3'd1);

    assign o_stat.func       = r_req.func;
    assign o_stat.phase      = r_phase;
    assign o_stat.tx_busy    = r_busy;
    assign o_stat.lifo_empty = empty;
    assign o_stat.sid_ok     = sid_ok;
    assign o_stat.cmd_ok     = cmd_ok;
    assign o_stat.cmd_data   = r_rxf[2] == sls_pkg::CMD_DATA;
    assign o_stat.scan_free  = !f_eff[0];
    assign o_stat.scan_end   = r_scan == scan_last;
    assign o_stat.sweep_last = r_sw == CW'(SLOT_BYTES - 1);
    assign o_stat.emit_last  = emit_last;

    assign o_result.tx_valid          = r_ntx != 3'd0;
    assign o_result.tx_byte           = (r_ntx != 3'd0) ? r_tx[r_eidx] : 8'h00;
    assign o_result.last              = emit_last;
    assign o_result.accepted          = r_acc;
    assign o_result.slot_out          = r_sout;
    assign o_result.read_data         = r_rdat;
    assign o_result.slot_is_open      = r_ropen;
    assign o_result.slot_is_connected = r_rconn;
    assign o_result.link_ready        = r_phase >= sls_pkg::PH_HEADER;

`ifndef SYNTH
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_level) <= PENDING_DEPTH)
        else $error("operation stack level above its depth");

    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ntx == 3'd0 || r_ntx == 3'd3 || r_ntx == 3'd4 || r_ntx == 3'd7)
        else $error("frame length is not 0, 3, 4 or 7");

    a_pop_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == sls_pkg::DP_POP) |-> (!r_busy && r_level != '0))
        else $error("pop while transmitter busy or stack empty");
`endif

endmodule

>>> design/sls_ctrl.sv
// ----------------------------------------------------------------------------
// sls_ctrl: sequencing state machine of the slotted link servicer
// Takes one request, steps the datapath through its work and hands out
// the result transactions one per cycle while the receiver holds i_ready high.
// ----------------------------------------------------------------------------
module sls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  sls_pkg::t_dp_stat i_stat,
    output sls_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RUNCMD,
        S_SWEEP,
        S_POP,
        S_SCAN,
        S_REQCHK,
        S_READCHK,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.op       = sls_pkg::DP_NONE;
        o_cmd.emit_adv = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_EMIT;
                unique case (i_stat.func) inside
                    sls_pkg::FN_POLL: begin
                        if (i_stat.phase == sls_pkg::PH_IDLE
                            || i_stat.phase == sls_pkg::PH_REPLY_SEEN) begin
                            if (!i_stat.tx_busy) begin
                                o_cmd.op = sls_pkg::DP_HS;
                            end
                        end else if (i_stat.phase == sls_pkg::PH_READY) begin
                            o_cmd.op = sls_pkg::DP_CMD_RD;
                            n_state  = S_RUNCMD;
                        end else if (i_stat.phase == sls_pkg::PH_HEADER
                                     || i_stat.phase == sls_pkg::PH_PAYLOAD) begin
                            n_state = S_POP;
                        end
                    end
                    sls_pkg::FN_RXBYTE: o_cmd.op = sls_pkg::DP_TAKE;
                    sls_pkg::FN_TXDONE: o_cmd.op = sls_pkg::DP_TXDONE;
                    sls_pkg::FN_OPEN: begin
                        o_cmd.op = sls_pkg::DP_SCAN_START;
                        n_state  = S_SCAN;
                    end
                    sls_pkg::FN_CLOSE, sls_pkg::FN_ACK: begin
                        if (i_stat.sid_ok) begin
                            o_cmd.op = sls_pkg::DP_REQ_RD;
                            n_state  = S_REQCHK;
                        end
                    end
                    sls_pkg::FN_READ: begin
                        if (i_stat.sid_ok) begin
                            o_cmd.op = sls_pkg::DP_REQ_RD;
                            n_state  = S_READCHK;
                        end
                    end
                    default: ;
                endcase
            end
            S_RUNCMD: begin
                o_cmd.op = sls_pkg::DP_CMD_EXEC;
                n_state  = (i_stat.cmd_ok && i_stat.cmd_data) ? S_SWEEP : S_POP;
            end
            S_SWEEP: begin
                o_cmd.op = sls_pkg::DP_SWEEP;
                if (i_stat.sweep_last) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (!i_stat.lifo_empty && !i_stat.tx_busy) begin
                    o_cmd.op = sls_pkg::DP_POP;
                end
                n_state = S_EMIT;
            end
            S_SCAN: begin
                if (i_stat.scan_free) begin
                    o_cmd.op = sls_pkg::DP_OPEN_COMMIT;
                    n_state  = S_EMIT;
                end else if (i_stat.scan_end) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.op = sls_pkg::DP_SCAN_NEXT;
                end
            end
            S_REQCHK: begin
                o_cmd.op = sls_pkg::DP_REQ_COMMIT;
                n_state  = S_EMIT;
            end
            S_READCHK: begin
                o_cmd.op = sls_pkg::DP_READ_COMMIT;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_ready) begin
                    o_cmd.emit_adv = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_state == S_IDLE;
            r_out_valid <= n_state == S_EMIT;
        end
    end

    assign o_ready = r_in_ready;
    assign o_valid = r_out_valid;

`ifndef SYNTH
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_ready && r_out_valid))
        else $error("input ready while a result is offered");

    a_hold_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_in_ready) |=> !r_in_ready)
        else $error("second request taken before results were delivered");
`endif

endmodule

>>> sim/tb_slotted_link_servicer.sv
// ----------------------------------------------------------------------------
// tb_slotted_link_servicer: self-checking bench for the slotted link servicer
// Runs the link handshake, then mixes well-formed command frames, slot
// requests, polls and noise. A scoreboard mirrors the link and slot state to
// predict every result transaction, and compares the results field by field.
// ----------------------------------------------------------------------------
module tb_slotted_link_servicer;

    localparam int NSLOT      = 256;
    localparam int SBYTES     = 16;
    localparam int LIFO_DEPTH = 6;
    localparam int FRAME_MAX  = SBYTES + 4;
    localparam int RAND_ITEMS = 290;
    localparam int CYCLE_CAP  = 1000000;
    localparam int HOLD_OFF   = 300;

    // The scoreboard keeps its own copy of the link state, slot flags and slot
    // data. A request is noted when it is taken, and the results it will
    // produce are queued in order.
    class link_scoreboard;
        bit [2:0]  phase;
        bit        tx_busy;
        int        rx_count;
        bit [7:0]  frame_buf[FRAME_MAX];
        bit [26:0] op_stack[LIFO_DEPTH];
        int        op_level;
        bit [1:0]  flags[NSLOT];
        bit [7:0]  store[NSLOT*SBYTES];
        bit        written[NSLOT];
        sls_pkg::t_out pending_results[$];
        int        errors;

        function void take_byte(bit [7:0] b);
            if (phase == sls_pkg::PH_WAIT_REPLY) begin
                if (rx_count < 3) frame_buf[rx_count] = b;
                rx_count++;
                if (rx_count >= 3) begin
                    if (frame_buf[0] == sls_pkg::SYNC_RX && frame_buf[1] == 8'h00 &&
                        frame_buf[2] == sls_pkg::HS_REPLY)
                        phase = sls_pkg::PH_REPLY_SEEN;
                    rx_count = 0;
                end
            end else if (phase == sls_pkg::PH_HEADER) begin
                if (rx_count < 3) frame_buf[rx_count] = b;
                rx_count++;
                if (rx_count >= 3)
                    phase = (frame_buf[1] != 0) ? sls_pkg::PH_PAYLOAD : sls_pkg::PH_READY;
            end else if (phase == sls_pkg::PH_PAYLOAD) begin
                if (rx_count < FRAME_MAX) frame_buf[rx_count] = b;
                rx_count++;
                if (rx_count >= 3 + int'(frame_buf[1])) phase = sls_pkg::PH_READY;
            end
        endfunction

        // Acts on a fully received frame; commands without a slot byte or with
        // a wrong sync byte are dropped.
        function void run_frame();
            int s;
            int n;
            if (frame_buf[0] != sls_pkg::SYNC_RX || frame_buf[1] == 0) return;
            s = frame_buf[3];
            case (frame_buf[2])
                sls_pkg::CMD_CONN:  flags[s][1] = 1'b1;
                sls_pkg::CMD_CLOSE: flags[s] = 2'b00;
                sls_pkg::CMD_DATA: begin
                    n = int'(frame_buf[1]) - 1;
                    if (n > SBYTES) n = SBYTES;
                    for (int i = 0; i < SBYTES; i++)
                        store[s*SBYTES+i] = (i < n) ? frame_buf[4+i] : 8'h00;
                    written[s] = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function bit push_op(bit [26:0] op);
            if (op_level >= LIFO_DEPTH) return 1'b0;
            op_stack[op_level] = op;
            op_level++;
            return 1'b1;
        endfunction

        function void note_request(sls_pkg::t_in r);
            bit [7:0] tx[7];
            int       ntx;
            int       nres;
            bit       acc;
            bit [7:0] sout;
            bit [7:0] rdat;
            bit       ropen;
            bit       rconn;
            bit       found;
            int       s;
            bit [26:0] op;
            sls_pkg::t_out o;
            ntx = 0; acc = 0; sout = 0; rdat = 0; ropen = 0; rconn = 0;
            found = 0; s = 0;
            foreach (tx[i]) tx[i] = 8'h00;
            case (r.func)
                sls_pkg::FN_POLL: begin
                    if (phase == sls_pkg::PH_IDLE || phase == sls_pkg::PH_REPLY_SEEN) begin
                        if (!tx_busy) begin
                            tx[0] = sls_pkg::SYNC_TX;
                            tx[1] = 8'h00;
                            tx[2] = (phase == sls_pkg::PH_IDLE) ? sls_pkg::HS_START
                                                                : sls_pkg::HS_DONE;
                            ntx = 3;
                            tx_busy = 1;
                            phase = (phase == sls_pkg::PH_IDLE) ? sls_pkg::PH_WAIT_REPLY
                                                                : sls_pkg::PH_HEADER;
                            rx_count = 0;
                        end
                    end else if (phase >= sls_pkg::PH_HEADER && phase <= sls_pkg::PH_READY)
                    begin
                        if (phase == sls_pkg::PH_READY) begin
                            run_frame();
                            phase = sls_pkg::PH_HEADER;
                            rx_count = 0;
                        end
                        if (op_level > 0 && !tx_busy) begin
                            op_level--;
                            op = op_stack[op_level];
                            tx[0] = sls_pkg::SYNC_TX;
                            if (op[26:24] <= 3'd1) begin
                                tx[1] = 8'h04; tx[2] = sls_pkg::FR_OPEN;
                                tx[3] = {5'd0, op[26:24]};
                                tx[4] = op[7:0]; tx[5] = op[15:8]; tx[6] = op[23:16];
                                ntx = 7;
                            end else begin
                                tx[1] = 8'h01;
                                tx[2] = (op[26:24] == sls_pkg::KIND_CLOSE) ? sls_pkg::FR_CLOSE
                                                                           : sls_pkg::FR_ACK;
                                tx[3] = op[7:0];
                                ntx = 4;
                            end
                            tx_busy = 1;
                        end
                    end
                end
                sls_pkg::FN_RXBYTE: take_byte(r.rx_byte);
                sls_pkg::FN_TXDONE: tx_busy = 0;
                sls_pkg::FN_OPEN: begin
                    // Persistent opens search from the top slot downward.
                    for (int i = 0; i < NSLOT && !found; i++) begin
                        s = r.persistent ? NSLOT - 1 - i : i;
                        if (!flags[s][0]) found = 1;
                    end
                    if (found && push_op({2'b00, r.continuous, r.data_id, s[7:0]})) begin
                        flags[s][0] = 1'b1;
                        acc = 1;
                        sout = s[7:0];
                    end
                end
                sls_pkg::FN_CLOSE:
                    if (flags[r.slot_id][0] &&
                        push_op({sls_pkg::KIND_CLOSE, 16'h0, r.slot_id}))
                        acc = 1;
                sls_pkg::FN_ACK:
                    if (flags[r.slot_id] == 2'b11 &&
                        push_op({sls_pkg::KIND_ACK, 16'h0, r.slot_id}))
                        acc = 1;
                sls_pkg::FN_READ: begin
                    ropen = flags[r.slot_id][0];
                    rconn = flags[r.slot_id][1];
                    rdat  = store[int'(r.slot_id)*SBYTES + int'(r.byte_index)];
                end
                default: ;
            endcase
            nres = (ntx != 0) ? ntx : 1;
            for (int i = 0; i < nres; i++) begin
                o.tx_valid          = (ntx != 0);
                o.tx_byte           = tx[i];
                o.last              = (i + 1 == nres);
                o.accepted          = acc;
                o.slot_out          = sout;
                o.read_data         = rdat;
                o.slot_is_open      = ropen;
                o.slot_is_connected = rconn;
                o.link_ready        = (phase >= sls_pkg::PH_HEADER);
                pending_results.push_back(o);
            end
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(sls_pkg::t_out got);
            sls_pkg::t_out want;
            if (pending_results.size() == 0) begin
                $error("result transaction with no request waiting for it");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare("tx_valid", want.tx_valid, got.tx_valid);
            compare("tx_byte", want.tx_byte, got.tx_byte);
            compare("last", want.last, got.last);
            compare("accepted", want.accepted, got.accepted);
            compare("slot_out", want.slot_out, got.slot_out);
            compare("read_data", want.read_data, got.read_data);
            compare("slot_is_open", want.slot_is_open, got.slot_is_open);
            compare("slot_is_connected", want.slot_is_connected, got.slot_is_connected);
            compare("link_ready", want.link_ready, got.link_ready);
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    sls_pkg::t_in  i_item;
    logic          o_valid;
    logic          i_ready;
    sls_pkg::t_out o_result;

    link_scoreboard sb;
    int  idle_mode;   // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
    bit  hold_req;
    int  cycle_count;
    int  n_taken;

    slotted_link_servicer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb_slotted_link_servicer: errors");
            $finish;
        end
    end

    // Receiver: ready is driven at the rising edge. A requested hold-off keeps
    // ready low for a long stretch so the block backs up into its input side.
    initial begin
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
                hold_req = 1'b0;
            end
            if ((idle_mode == 2 && $urandom_range(0, 99) < 65) ||
                (idle_mode == 3 && $urandom_range(0, 99) < 37))
                i_ready <= 1'b0;
            else
                i_ready <= 1'b1;
        end
    end

    // Outputs are sampled at the falling edge, where they are settled; a
    // result seen with ready high there is taken at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_result);
    end

    // Offers one request, with an optional idle gap first, and returns just
    // after the edge at which the transaction completes.
    task automatic send_req(sls_pkg::t_in r);
        if ((idle_mode == 1 && $urandom_range(0, 99) < 65) ||
            (idle_mode == 3 && $urandom_range(0, 99) < 37)) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= r;
        do @(negedge i_clk); while (!o_ready);
        sb.note_request(r);
        n_taken++;
        @(posedge i_clk);
    endtask

    // Request with random don't-care fields, so every input bit toggles.
    function automatic sls_pkg::t_in rand_req(bit [2:0] f);
        sls_pkg::t_in r;
        r.func       = f;
        r.rx_byte    = $urandom;
        r.slot_id    = $urandom;
        r.data_id    = $urandom;
        r.continuous = $urandom;
        r.persistent = $urandom;
        r.byte_index = $urandom;
        return r;
    endfunction

    task automatic send_func(bit [2:0] f);
        send_req(rand_req(f));
    endtask

    task automatic send_byte(bit [7:0] b);
        sls_pkg::t_in r;
        r = rand_req(sls_pkg::FN_RXBYTE);
        r.rx_byte = b;
        send_req(r);
    endtask

    task automatic send_slot_req(bit [2:0] f, bit [7:0] slot);
        sls_pkg::t_in r;
        r = rand_req(f);
        r.slot_id = slot;
        send_req(r);
    endtask

    // Sends a command frame byte by byte, then the poll that executes it.
    task automatic send_frame(bit [7:0] sync, bit [7:0] len, bit [7:0] cmd, bit [7:0] slot);
        send_byte(sync);
        send_byte(len);
        send_byte(cmd);
        for (int i = 0; i < len; i++) send_byte(i == 0 ? slot : 8'($urandom));
        send_func(sls_pkg::FN_POLL);
    endtask

    // Most traffic targets a few slots at each end so flags interact.
    function automatic bit [7:0] pick_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 7);
        if (r < 80) return $urandom_range(NSLOT - 8, NSLOT - 1);
        return $urandom_range(0, NSLOT - 1);
    endfunction

    task automatic send_read();
        sls_pkg::t_in r;
        bit [7:0] s;
        int tries;
        s = pick_slot();
        tries = 0;
        while (!sb.written[s] && tries < 64) begin
            s = pick_slot();
            tries++;
        end
        // Never read slot data that was never stored.
        if (!sb.written[s]) begin
            send_func(sls_pkg::FN_POLL);
        end else begin
            r = rand_req(sls_pkg::FN_READ);
            r.slot_id = s;
            send_req(r);
        end
    endtask

    task automatic random_traffic();
        int r;
        bit [7:0] cmd;
        bit [7:0] len;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            case ($urandom_range(0, 2))
                0: cmd = sls_pkg::CMD_CONN;
                1: cmd = sls_pkg::CMD_CLOSE;
                default: cmd = sls_pkg::CMD_DATA;
            endcase
            if (cmd == sls_pkg::CMD_DATA)
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24)
                                                  : $urandom_range(1, 8);
            else
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 4) : 8'd1;
            send_frame(sls_pkg::SYNC_RX, len, cmd, pick_slot());
        end else if (r < 44) begin
            send_func(sls_pkg::FN_OPEN);
        end else if (r < 53) begin
            send_slot_req(sls_pkg::FN_CLOSE, pick_slot());
        end else if (r < 61) begin
            send_slot_req(sls_pkg::FN_ACK, pick_slot());
        end else if (r < 68) begin
            send_read();
        end else if (r < 80) begin
            send_func(sls_pkg::FN_POLL);
        end else if (r < 90) begin
            send_func(sls_pkg::FN_TXDONE);
        end else if (r < 95) begin
            send_func(sls_pkg::FN_RXBYTE);
        end else if (r < 97) begin
            // Broken frame: a header cut off after its length byte.
            send_byte(sls_pkg::SYNC_RX);
            send_byte($urandom_range(3, 9));
            send_func(sls_pkg::FN_POLL);
        end else begin
            send_func(3'd7);
        end
    endtask

    initial begin
        sb = new();
        idle_mode   = 0;
        hold_req    = 1'b0;
        cycle_count = 0;
        n_taken     = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a byte before the link is up is dropped, a bad reply is
        // discarded, and the second handshake frame waits for a free sender.
        send_byte(8'h55);
        send_func(sls_pkg::FN_POLL);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(sls_pkg::SYNC_RX);
        send_byte(8'h00);
        send_byte(sls_pkg::HS_REPLY);
        send_func(sls_pkg::FN_POLL);
        send_func(sls_pkg::FN_TXDONE);
        send_func(sls_pkg::FN_POLL);
        begin
            sls_pkg::t_in r;
            r = rand_req(sls_pkg::FN_OPEN);
            r.continuous = 1; r.persistent = 0; r.data_id = 16'hFFFF;
            send_req(r);
            r.continuous = 0; r.persistent = 1; r.data_id = 16'h0000;
            send_req(r);
        end
        send_func(sls_pkg::FN_POLL);
        send_func(sls_pkg::FN_TXDONE);
        send_func(sls_pkg::FN_POLL);
        send_func(sls_pkg::FN_TXDONE);
        send_frame(sls_pkg::SYNC_RX, 8'd1, sls_pkg::CMD_CONN, 8'd0);
        send_slot_req(sls_pkg::FN_ACK, 8'd0);
        send_slot_req(sls_pkg::FN_CLOSE, 8'd255);
        send_frame(sls_pkg::SYNC_RX, 8'd18, sls_pkg::CMD_DATA, 8'd0);
        send_frame(sls_pkg::SYNC_RX, 8'd0, sls_pkg::CMD_DATA, 8'd0);
        send_frame(sls_pkg::SYNC_RX, 8'd2, 8'h77, 8'd1);
        send_frame(8'h5A, 8'd1, sls_pkg::CMD_CONN, 8'd2);
        send_func(3'd7);
        // Fill the operation stack so later opens are turned away.
        repeat (LIFO_DEPTH + 1) send_func(sls_pkg::FN_OPEN);

        // Random traffic in four idle phases; the long receiver hold-off
        // happens early in the first one.
        for (int i = 0; i < RAND_ITEMS && n_taken < RAND_ITEMS + 20; ) begin
            idle_mode = (i * 4) / RAND_ITEMS;
            if (i == 10) hold_req = 1'b1;
            random_traffic();
            i++;
        end
        i_valid <= 1'b0;
        idle_mode = 0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("tb_slotted_link_servicer: clean");
        else
            $display("tb_slotted_link_servicer: errors");
        $finish;
    end
endmodule

>>> files.f
design/sls_pkg.sv
design/sls_datapath.sv
design/sls_ctrl.sv
design/slotted_link_servicer.sv
sim/tb_slotted_link_servicer.sv
